// ===== sv/dbc_pkg.sv =====
`default_nettype none
package dbc_pkg;

  localparam int SN_W    = 18;
  localparam int TAG_W   = 16;
  localparam int SIZE_W  = 19;
  localparam int DELAY_W = 10;
  localparam int CFG_W   = 10;
  localparam int CFG_IDX_W = 1;

  localparam logic [SIZE_W-1:0] SIZE_CAP = 19'd262144;

  localparam logic [1:0] FUNC_DISCARD = 2'd0;
  localparam logic [1:0] FUNC_SDU     = 2'd1;
  localparam logic [1:0] FUNC_TICK    = 2'd2;

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_DISCARD = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_BEARER_STOPPED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOTIFY_DELAY   = 1'd1;

  typedef struct packed {
    logic [1:0]       func;
    logic [SN_W-1:0]  pdcp_sn;
    logic [TAG_W-1:0] sdu_tag;
  } in_item_t;

  typedef struct packed {
    logic              message_kind;
    logic [SN_W-1:0]   out_sn;
    logic [TAG_W-1:0]  out_tag;
    logic              has_block;
    logic [SN_W-1:0]   block_start;
    logic [SIZE_W-1:0] run_size;
    logic              last;
  } result_t;

  // one message to stream, minus the run count
  typedef struct packed {
    logic             kind;
    logic [SN_W-1:0]  sn;
    logic [TAG_W-1:0] tag;
  } cmd_t;

  // run store write request, minus the address
  typedef struct packed {
    logic              en;
    logic [SN_W-1:0]   start;
    logic [SIZE_W-1:0] size;
  } run_wr_t;

endpackage
`default_nettype wire

// ===== sv/dbc_cmd_fifo.sv =====
`default_nettype none
module dbc_cmd_fifo import dbc_pkg::*; #(
  parameter int CNT_W = 5
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire cmd_t             push_cmd,
  input  wire logic [CNT_W-1:0] push_count,
  input  wire logic             pop,
  output logic                  empty,
  output cmd_t                  head_cmd,
  output logic [CNT_W-1:0]      head_count
);

  cmd_t             cmd_q [2];
  logic [CNT_W-1:0] cnt_q [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;

  assign empty      = (fill == 2'd0);
  assign head_cmd   = cmd_q[rd_ptr];
  assign head_count = cnt_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      cmd_q[wr_ptr] <= push_cmd;
      cnt_q[wr_ptr] <= push_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop && !empty) rd_ptr <= ~rd_ptr;
      case ({push, pop && !empty})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/dbc_front.sv =====
`default_nettype none
module dbc_front import dbc_pkg::*; #(
  parameter int MAX_BLOCKS = 16,
  parameter int SN_BITS    = 18,
  parameter int CNT_W      = 5,
  parameter int IDX_W      = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire in_item_t             item,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output logic                      push,
  output cmd_t                      push_cmd,
  output logic [CNT_W-1:0]          push_count,
  output run_wr_t                   wr,
  output logic [IDX_W-1:0]          wr_addr
);

  localparam int SN_KEEP = (SN_BITS < SN_W) ? SN_BITS : SN_W;
  localparam logic [SN_W-1:0]  SN_MASK = SN_W'((64'd1 << SN_KEEP) - 64'd1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCKS);

  logic                stopped;
  logic [DELAY_W-1:0]  delay;
  logic [CNT_W-1:0]    run_count, run_count_next;
  logic                timer_running, timer_running_next;
  logic [DELAY_W-1:0]  timer_left, timer_left_next;
  logic [SN_W-1:0]     last_start, last_start_next;
  logic [SIZE_W-1:0]   last_size, last_size_next;

  logic [SN_W-1:0]     sn_m;
  logic [SIZE_W:0]     run_end;
  logic [DELAY_W-1:0]  left_dec;
  logic [CNT_W-1:0]    count_inc;

  assign sn_m      = item.pdcp_sn & SN_MASK;
  // unwrapped end of the last run
  assign run_end   = {1'b0, 1'b0, last_start} + {1'b0, last_size};
  assign left_dec  = (timer_left != '0) ? timer_left - DELAY_W'(1) : timer_left;
  assign count_inc = run_count + CNT_W'(1);

  always_comb begin
    run_count_next     = run_count;
    timer_running_next = timer_running;
    timer_left_next    = timer_left;
    last_start_next    = last_start;
    last_size_next     = last_size;
    push               = 1'b0;
    push_cmd           = '0;
    push_count         = '0;
    wr                 = '0;
    wr_addr            = run_count[IDX_W-1:0];
    if (accept) begin
      case (item.func)
        FUNC_DISCARD: begin
          if (!stopped) begin
            if (!timer_running) begin
              timer_running_next = 1'b1;
              timer_left_next    = (delay == '0) ? DELAY_W'(1) : delay;
            end
            if (run_count != '0 && run_end == {2'b00, sn_m} && last_size != SIZE_CAP) begin
              last_size_next = last_size + SIZE_W'(1);
              wr.en    = 1'b1;
              wr.start = last_start;
              wr.size  = last_size + SIZE_W'(1);
              wr_addr  = IDX_W'(run_count - CNT_W'(1));
            end else begin
              wr.en           = 1'b1;
              wr.start        = sn_m;
              wr.size         = SIZE_W'(1);
              last_start_next = sn_m;
              last_size_next  = SIZE_W'(1);
              if (count_inc == MAX_CNT) begin
                // store full: flush as a discard-only message
                push               = 1'b1;
                push_cmd.kind      = KIND_DISCARD;
                push_count         = MAX_CNT;
                run_count_next     = '0;
                timer_running_next = 1'b0;
                timer_left_next    = '0;
              end else begin
                run_count_next = count_inc;
              end
            end
          end
        end
        FUNC_SDU: begin
          if (!stopped) begin
            push               = 1'b1;
            push_cmd.kind      = KIND_DATA;
            push_cmd.sn        = sn_m;
            push_cmd.tag       = item.sdu_tag;
            push_count         = run_count;
            run_count_next     = '0;
            timer_running_next = 1'b0;
            timer_left_next    = '0;
          end
        end
        FUNC_TICK: begin
          if (timer_running) begin
            if (left_dec == '0) begin
              push               = (run_count != '0);
              push_cmd.kind      = KIND_DISCARD;
              push_count         = run_count;
              run_count_next     = '0;
              timer_running_next = 1'b0;
              timer_left_next    = '0;
            end else begin
              timer_left_next = left_dec;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stopped       <= 1'b0;
      delay         <= DELAY_W'(10);
      run_count     <= '0;
      timer_running <= 1'b0;
      timer_left    <= '0;
    end else begin
      run_count     <= run_count_next;
      timer_running <= timer_running_next;
      timer_left    <= timer_left_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_BEARER_STOPPED: stopped <= cfg_data[0];
          CFG_NOTIFY_DELAY:   delay   <= cfg_data[DELAY_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    last_start <= last_start_next;
    last_size  <= last_size_next;
  end

endmodule
`default_nettype wire

// ===== sv/dbc_back.sv =====
`default_nettype none
module dbc_back import dbc_pkg::*; #(
  parameter int MAX_BLOCKS = 16,
  parameter int CNT_W      = 5,
  parameter int IDX_W      = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire run_wr_t          wr,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire logic             cmd_empty,
  input  wire cmd_t             cmd,
  input  wire logic [CNT_W-1:0] cmd_count,
  output logic                  cmd_pop,
  output logic                  active,
  output logic                  result_valid,
  output result_t               result
);

  logic [SN_W-1:0]   mem_start [MAX_BLOCKS];
  logic [SIZE_W-1:0] mem_size  [MAX_BLOCKS];

  logic [IDX_W-1:0]  rd_idx;
  logic [CNT_W-1:0]  cur_count;
  cmd_t              cur_cmd;
  logic [SN_W-1:0]   rd_start;
  logic [SIZE_W-1:0] rd_size;

  logic              out_has;
  logic              out_last;
  cmd_t              out_cmd;
  logic              is_last;

  assign cmd_pop = !active && !cmd_empty;
  assign is_last = (CNT_W'(rd_idx) + CNT_W'(1)) == cur_count;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_start[wr_addr] <= wr.start;
      mem_size[wr_addr]  <= wr.size;
    end
    rd_start <= mem_start[rd_idx];
    rd_size  <= mem_size[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      result_valid <= 1'b0;
      rd_idx       <= '0;
    end else begin
      result_valid <= 1'b0;
      if (active) begin
        // one run read per cycle, data lands with the strobe
        result_valid <= 1'b1;
        rd_idx       <= rd_idx + IDX_W'(1);
        if (is_last) active <= 1'b0;
      end else if (cmd_pop) begin
        rd_idx <= '0;
        if (cmd_count == '0) begin
          result_valid <= 1'b1;
        end else begin
          active <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      out_has  <= 1'b1;
      out_last <= is_last;
      out_cmd  <= cur_cmd;
    end else if (cmd_pop) begin
      // popped command is latched; an sdu with no runs is a single beat without a block
      out_has   <= 1'b0;
      out_last  <= 1'b1;
      out_cmd   <= cmd;
      cur_cmd   <= cmd;
      cur_count <= cmd_count;
    end
  end

  always_comb begin
    result.message_kind = out_cmd.kind;
    result.out_sn       = out_cmd.sn;
    result.out_tag      = out_cmd.tag;
    result.has_block    = out_has;
    result.block_start  = out_has ? rd_start : '0;
    result.run_size     = out_has ? rd_size : '0;
    result.last         = out_last;
  end

endmodule
`default_nettype wire

// ===== sv/discard_block_coalescer.sv =====
`default_nettype none
// discard run coalescer
// input channel: an item (func, pdcp_sn, sdu_tag) is taken on a clock edge with
// start high and busy low. discards and ticks are absorbed at that edge and
// update the run store and the backoff timer in the front part.
// an item that emits a message (sdu, store full, timer expiry) queues a command
// to the back part, which streams the message one beat per cycle from the run
// store: result_valid is high for exactly one cycle per beat, last marks the
// final beat. a command is queued at the accepting edge, then popped by the back
// part; its runs are then read out one beat per cycle, or one bare beat if none.
// busy stays high while a message is queued or being read out, so the block
// takes no new item until the last beat is shown; other items leave busy low.
// the receiver cannot stall: every beat is taken in the cycle it is shown.
// configuration (bearer_stopped index 0, notify_delay_ms index 1) is written with
// cfg_we at any edge and is meant to change only while the block is idle.
// synchronous reset clears the run count, the timer and the queue and restores
// bearer_stopped 0 and notify_delay_ms 10; no clearing pass is needed.
module discard_block_coalescer import dbc_pkg::*; #(
  parameter int MAX_BLOCKS = 16,
  parameter int SN_BITS    = 18
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire in_item_t             item,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output logic                      result_valid,
  output result_t                   result
);

  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int IDX_W = $clog2(MAX_BLOCKS);

  logic             accept;
  logic             push;
  cmd_t             push_cmd;
  logic [CNT_W-1:0] push_count;
  run_wr_t          wr;
  logic [IDX_W-1:0] wr_addr;
  logic             cmd_pop;
  logic             cmd_empty;
  cmd_t             head_cmd;
  logic [CNT_W-1:0] head_count;
  logic             back_active;

  assign busy   = !cmd_empty || back_active;
  assign accept = start && !busy;

  dbc_front #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SN_BITS    (SN_BITS),
    .CNT_W      (CNT_W),
    .IDX_W      (IDX_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item       (item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_count (push_count),
    .wr         (wr),
    .wr_addr    (wr_addr)
  );

  dbc_cmd_fifo #(
    .CNT_W (CNT_W)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_count (push_count),
    .pop        (cmd_pop),
    .empty      (cmd_empty),
    .head_cmd   (head_cmd),
    .head_count (head_count)
  );

  dbc_back #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .CNT_W      (CNT_W),
    .IDX_W      (IDX_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .wr           (wr),
    .wr_addr      (wr_addr),
    .cmd_empty    (cmd_empty),
    .cmd          (head_cmd),
    .cmd_count    (head_count),
    .cmd_pop      (cmd_pop),
    .active       (back_active),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
`default_nettype wire

// ===== test/discard_block_coalescer_test.sv =====
`timescale 1ns / 1ps

module discard_block_coalescer_test import dbc_pkg::*; ();

  localparam int MAX_RUNS = 16;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [SN_W-1:0] SN_TOP = '1;
  localparam logic [TAG_W-1:0] TAG_TOP = '1;

  // mirrors the run store and backoff timer, queues the beats each item should emit
  class run_message_tracker;
    logic [SN_W-1:0]    run_start [MAX_RUNS];
    logic [SIZE_W-1:0]  run_len [MAX_RUNS];
    int                 run_count;
    bit                 timer_on;
    logic [DELAY_W-1:0] timer_left;
    bit                 stopped;
    logic [DELAY_W-1:0] delay;
    result_t            due_beats [$];
    int                 bad_beats;

    function new();
      run_count = 0;
      timer_on = 0;
      timer_left = '0;
      stopped = 0;
      delay = DELAY_W'(10);
      bad_beats = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == CFG_BEARER_STOPPED) stopped = data[0];
      else if (idx == CFG_NOTIFY_DELAY) delay = data[DELAY_W-1:0];
    endfunction

    function void emit_message(logic kind, logic [SN_W-1:0] sn, logic [TAG_W-1:0] tag);
      result_t b;
      int i;
      for (i = 0; i < run_count; i++) begin
        b.message_kind = kind;
        b.out_sn = sn;
        b.out_tag = tag;
        b.has_block = 1'b1;
        b.block_start = run_start[i];
        b.run_size = run_len[i];
        b.last = (i == run_count - 1);
        due_beats.insert(due_beats.size(), b);
      end
      run_count = 0;
      timer_on = 0;
      timer_left = '0;
    endfunction

    function void take_item(in_item_t it);
      result_t b;
      int last_i;
      int run_end;
      case (it.func)
        FUNC_DISCARD: begin
          if (stopped) return;
          if (!timer_on) begin
            timer_on = 1;
            timer_left = (delay == '0) ? DELAY_W'(1) : delay;
          end
          if (run_count > 0) begin
            last_i = run_count - 1;
            // unwrapped end: a run reaching the top never joins one at zero
            run_end = int'(run_start[last_i]) + int'(run_len[last_i]);
            if (run_end == int'(it.pdcp_sn) && run_len[last_i] < SIZE_CAP) begin
              run_len[last_i] = run_len[last_i] + SIZE_W'(1);
              return;
            end
          end
          run_start[run_count] = it.pdcp_sn;
          run_len[run_count] = SIZE_W'(1);
          run_count++;
          if (run_count >= MAX_RUNS) emit_message(KIND_DISCARD, '0, '0);
        end
        FUNC_SDU: begin
          if (stopped) return;
          if (run_count == 0) begin
            timer_on = 0;
            timer_left = '0;
            b.message_kind = KIND_DATA;
            b.out_sn = it.pdcp_sn;
            b.out_tag = it.sdu_tag;
            b.has_block = 1'b0;
            b.block_start = '0;
            b.run_size = '0;
            b.last = 1'b1;
            due_beats.insert(due_beats.size(), b);
          end else begin
            emit_message(KIND_DATA, it.pdcp_sn, it.sdu_tag);
          end
        end
        FUNC_TICK: begin
          if (!timer_on) return;
          if (timer_left > 0) timer_left = timer_left - DELAY_W'(1);
          if (timer_left == 0) emit_message(KIND_DISCARD, '0, '0);
        end
        default: ;
      endcase
    endfunction

    function string beat_text(result_t b);
      return $sformatf("kind=%0d sn=%0d tag=%0d has=%0d start=%0d size=%0d last=%0d",
                       b.message_kind, b.out_sn, b.out_tag, b.has_block,
                       b.block_start, b.run_size, b.last);
    endfunction

    function void check_beat(result_t got);
      result_t want;
      if (due_beats.size() == 0) begin
        bad_beats++;
        if (bad_beats <= 10) $display("%0t beat with none due: %s", $time, beat_text(got));
        return;
      end
      want = due_beats.pop_front();
      if (got.message_kind !== want.message_kind || got.out_sn !== want.out_sn ||
          got.out_tag !== want.out_tag || got.has_block !== want.has_block ||
          got.block_start !== want.block_start || got.run_size !== want.run_size ||
          got.last !== want.last) begin
        bad_beats++;
        if (bad_beats <= 10)
          $display("%0t beat mismatch\n  want %s\n  got  %s", $time,
                   beat_text(want), beat_text(got));
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  in_item_t             item;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 result_valid;
  result_t              out_beat;

  run_message_tracker tracker = new();
  logic [SN_W-1:0] next_sn;

  int phase_delay [5]   = '{4, 1, 1023, 0, 3};
  int phase_stopped [5] = '{0, 0, 0, 0, 1};
  int phase_idle [5]    = '{0, 84, 7, 0, 84};
  int phase_items [5]   = '{50, 50, 50, 40, 40};

  discard_block_coalescer dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result       (out_beat)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) tracker.set_reg(cfg_index, cfg_data);
      if (start && !busy) tracker.take_item(item);
      if (result_valid) tracker.check_beat(out_beat);
    end
  end

  task automatic send_item(input logic [1:0] f, input logic [SN_W-1:0] sn,
                           input logic [TAG_W-1:0] tag);
    in_item_t it;
    it.func = f;
    it.pdcp_sn = sn;
    it.sdu_tag = tag;
    @(negedge clk);
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause_cycle();
    @(negedge clk);
    start <= 1'b0;
  endtask

  // hold off until every due beat has come out and the block is quiet
  task automatic drain_results();
    pause_cycle();
    while (tracker.due_beats.size() != 0 || busy) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_random_item();
    int r;
    int pick;
    logic [SN_W-1:0] sn;
    r = $urandom_range(99);
    if (r < 60) begin
      // mostly continue the current run, sometimes jump
      if ($urandom_range(9) < 7) begin
        sn = next_sn;
      end else begin
        pick = $urandom_range(9);
        if (pick == 0) sn = '0;
        else if (pick == 1) sn = SN_TOP;
        else sn = SN_W'($urandom_range(0, 262143));
      end
      next_sn = sn + 1'b1;
      send_item(FUNC_DISCARD, sn, TAG_W'($urandom_range(0, 65535)));
    end else if (r < 72) begin
      send_item(FUNC_SDU, SN_W'($urandom_range(0, 262143)), TAG_W'($urandom_range(0, 65535)));
    end else if (r < 95) begin
      send_item(FUNC_TICK, SN_W'($urandom_range(0, 262143)), TAG_W'($urandom_range(0, 65535)));
    end else begin
      send_item(FUNC_UNUSED, SN_W'($urandom_range(0, 262143)),
                TAG_W'($urandom_range(0, 65535)));
    end
  endtask

  initial begin
    int p;
    int k;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    next_sn = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // reset settings: running bearer, delay 10
    send_item(FUNC_SDU, SN_TOP, TAG_TOP);
    send_item(FUNC_SDU, '0, '0);
    send_item(FUNC_DISCARD, SN_W'(262140), '0);
    send_item(FUNC_DISCARD, SN_W'(262141), '0);
    send_item(FUNC_DISCARD, SN_W'(262142), '0);
    send_item(FUNC_DISCARD, SN_TOP, TAG_TOP);
    send_item(FUNC_DISCARD, '0, '0);
    send_item(FUNC_DISCARD, SN_W'(1), '0);
    send_item(FUNC_UNUSED, SN_TOP, TAG_TOP);
    for (k = 0; k < 10; k++) send_item(FUNC_TICK, '0, '0);
    send_item(FUNC_TICK, SN_TOP, TAG_TOP);
    for (k = 0; k < MAX_RUNS; k++) send_item(FUNC_DISCARD, SN_W'(k * 9973 + 5), '0);
    send_item(FUNC_DISCARD, SN_W'(7), '0);
    send_item(FUNC_DISCARD, SN_W'(8), '0);
    send_item(FUNC_SDU, SN_W'(5), 16'hABCD);
    drain_results();

    // short delay, then change it while the timer is already counting
    write_reg(CFG_NOTIFY_DELAY, CFG_W'(5));
    send_item(FUNC_DISCARD, SN_W'(42), '0);
    for (k = 0; k < 4; k++) send_item(FUNC_TICK, '0, '0);
    drain_results();
    write_reg(CFG_NOTIFY_DELAY, CFG_W'(1));
    send_item(FUNC_TICK, '0, '0);
    send_item(FUNC_DISCARD, SN_W'(100), '0);
    drain_results();

    // stopped bearer: discards and sdus dropped, ticks still flush held runs
    write_reg(CFG_BEARER_STOPPED, CFG_W'(1));
    send_item(FUNC_DISCARD, SN_W'(101), '0);
    send_item(FUNC_SDU, SN_W'(3), TAG_W'(3));
    send_item(FUNC_TICK, '0, '0);
    drain_results();

    for (p = 0; p < 5; p++) begin
      write_reg(CFG_BEARER_STOPPED, CFG_W'(phase_stopped[p]));
      write_reg(CFG_NOTIFY_DELAY, CFG_W'(phase_delay[p]));
      for (k = 0; k < phase_items[p]; k++) begin
        while ($urandom_range(99) < phase_idle[p]) pause_cycle();
        send_random_item();
        if ($urandom_range(49) == 0) drain_results();
      end
      drain_results();
    end

    // running bearer again: an sdu with no runs, then one with a single run
    write_reg(CFG_BEARER_STOPPED, CFG_W'(0));
    send_item(FUNC_SDU, SN_W'(9), TAG_W'(9));
    send_item(FUNC_DISCARD, '0, '0);
    send_item(FUNC_SDU, SN_W'(12), TAG_W'(12));
    pause_cycle();

    while (tracker.due_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.bad_beats == 0 && tracker.due_beats.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
